[hdl/ekvc_pkg.sv]
`timescale 1ns / 1ps

package ekvc_pkg;

	// Field widths of the stream payload
	localparam int OP_W     = 2;
	localparam int IDX_W    = 8;
	localparam int VOICE_W  = 49;
	localparam int STATUS_W = 3;
	localparam int LFSR_W   = 15;

	// Configuration register widths and indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_TYPE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ID        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCRAMBLER_KEY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = 2'd3;

	// Operation codes on the input
	localparam logic [OP_W-1:0] OP_CRYPT = 2'd0;
	localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Key rules
	localparam logic [1:0]  CIPHER_SCRAMBLER  = 2'd1;
	localparam logic [5:0]  KEY_LEN_SCRAMBLER = 6'd2;
	localparam logic [7:0]  KEY_ID_MAX        = 8'd63;
	localparam logic [15:0] KEY_MAX           = 16'h7FFF;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_CRYPTED = 3'd0;
	localparam logic [STATUS_W-1:0] STS_NO_KS   = 3'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE   = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BUILT   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_REFUSED = 3'd4;

	// Item kind as sorted by the front end
	typedef enum logic [1:0] {
		KIND_CRYPT,
		KIND_BUILD,
		KIND_CLEAR,
		KIND_PASS
	} kind_t;

	// One queued item
	typedef struct packed {
		kind_t              kind;
		logic               out_of_range;
		logic [IDX_W-1:0]   word_index;
		logic [VOICE_W-1:0] voice_bits;
	} q_item_t;

	// Configuration register file contents
	typedef struct packed {
		logic [1:0]  cipher_type;
		logic [7:0]  key_id;
		logic [15:0] scrambler_key;
		logic [5:0]  key_length;
	} cfg_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_BUILD,
		BK_EMIT
	} back_state_t;

endpackage

[hdl/ekvc_front.sv]
`timescale 1ns / 1ps

module ekvc_front #(
	parameter int WORDS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [1:0]             s_tuser,   // op
	input  logic [63:0]            s_tdata,   // word_index[7:0], voice_bits[56:8], zero pad
	output logic                   q_valid,
	output ekvc_pkg::q_item_t      q_item,
	input  logic                   q_pop
);

	ekvc_pkg::q_item_t item_in;
	ekvc_pkg::q_item_t entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;

	// Sort the incoming beat by operation and check the word range
	always_comb begin
		item_in.word_index   = s_tdata[ekvc_pkg::IDX_W-1:0];
		item_in.voice_bits   = s_tdata[ekvc_pkg::IDX_W +: ekvc_pkg::VOICE_W];
		item_in.out_of_range = ({1'b0, s_tdata[ekvc_pkg::IDX_W-1:0]} >= 9'(WORDS));
		case (s_tuser)
			ekvc_pkg::OP_CRYPT: item_in.kind = ekvc_pkg::KIND_CRYPT;
			ekvc_pkg::OP_BUILD: item_in.kind = ekvc_pkg::KIND_BUILD;
			ekvc_pkg::OP_CLEAR: item_in.kind = ekvc_pkg::KIND_CLEAR;
			default:            item_in.kind = ekvc_pkg::KIND_PASS;
		endcase
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	// Two-entry queue towards the back end
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	// Queue bookkeeping checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0)
		else $error("pop from empty queue");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");

endmodule

[hdl/ekvc_back.sv]
`timescale 1ns / 1ps

module ekvc_back #(
	parameter int WORDS     = 32,
	parameter int AMBE_BITS = 49
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ekvc_pkg::cfg_t                  cfg,
	input  logic                            q_valid,
	input  ekvc_pkg::q_item_t               q_item,
	output logic                            q_pop,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ekvc_pkg::VOICE_W-1:0]    result_bits,
	output logic [ekvc_pkg::STATUS_W-1:0]   status
);

	localparam int WIDX = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW   = (AMBE_BITS > 1) ? $clog2(AMBE_BITS) : 1;

	ekvc_pkg::back_state_t state_q, state_nx;

	// Keystream memory
	logic [AMBE_BITS-1:0] ks_mem [WORDS];
	logic [AMBE_BITS-1:0] rd_q;
	logic [63:0]          ks_ext;

	// Build walker
	logic [ekvc_pkg::LFSR_W-1:0] lfsr_q;
	logic [ekvc_pkg::LFSR_W-1:0] lfsr_nx;
	logic [AMBE_BITS-1:0]        slice_q;
	logic [AMBE_BITS-1:0]        slice_nx;
	logic [WIDX-1:0]             word_q;
	logic [BW-1:0]               bit_q;
	logic                        last_bit;
	logic                        last_word;

	// Pending result
	logic [ekvc_pkg::VOICE_W-1:0]  pend_bits_q;
	logic [ekvc_pkg::STATUS_W-1:0] pend_status_q;
	logic                          pend_xor_q;
	logic                          ks_valid_q;

	// Decode and control
	logic                          key_ok;
	logic                          crypt_hit;
	logic                          build_go;
	logic [ekvc_pkg::VOICE_W-1:0]  dec_bits;
	logic [ekvc_pkg::STATUS_W-1:0] dec_status;
	logic                          dec_drop;
	logic                          out_free;
	logic                          mem_re;
	logic                          mem_we;
	logic                          load_out;
	logic                          m_tvalid_q;
	logic [ekvc_pkg::VOICE_W-1:0]  res_q;
	logic [ekvc_pkg::STATUS_W-1:0] status_q;

	assign out_free = !m_tvalid_q || m_tready;

	// Key check against the current registers
	assign key_ok = (cfg.cipher_type == ekvc_pkg::CIPHER_SCRAMBLER)
		&& (cfg.key_length == ekvc_pkg::KEY_LEN_SCRAMBLER)
		&& (cfg.key_id != 8'd0) && (cfg.key_id <= ekvc_pkg::KEY_ID_MAX)
		&& (cfg.scrambler_key != 16'd0) && (cfg.scrambler_key <= ekvc_pkg::KEY_MAX);

	assign crypt_hit = ks_valid_q && (cfg.cipher_type == ekvc_pkg::CIPHER_SCRAMBLER)
		&& !q_item.out_of_range;

	// Item decode: result carried to the emit step
	always_comb begin
		dec_bits   = q_item.voice_bits;
		dec_status = ekvc_pkg::STS_NO_KS;
		dec_drop   = 1'b0;
		build_go   = 1'b0;
		case (q_item.kind)
			ekvc_pkg::KIND_CRYPT: begin
				if (!ks_valid_q || cfg.cipher_type != ekvc_pkg::CIPHER_SCRAMBLER) begin
					dec_status = ekvc_pkg::STS_NO_KS;
				end else if (q_item.out_of_range) begin
					dec_status = ekvc_pkg::STS_RANGE;
				end else begin
					dec_status = ekvc_pkg::STS_CRYPTED;
				end
			end
			ekvc_pkg::KIND_BUILD: begin
				dec_bits = '0;
				if (key_ok) begin
					dec_status = ekvc_pkg::STS_BUILT;
					build_go   = 1'b1;
				end else begin
					dec_status = ekvc_pkg::STS_REFUSED;
					dec_drop   = 1'b1;
				end
			end
			ekvc_pkg::KIND_CLEAR: begin
				dec_bits   = '0;
				dec_status = ekvc_pkg::STS_NO_KS;
				dec_drop   = 1'b1;
			end
			default: begin
				dec_status = ekvc_pkg::STS_NO_KS;
			end
		endcase
	end

	// LFSR step and slice shift; first keystream bit ends up at the top
	assign lfsr_nx   = {lfsr_q[0] ^ lfsr_q[1], lfsr_q[ekvc_pkg::LFSR_W-1:1]};
	assign slice_nx  = (slice_q << 1) | AMBE_BITS'(lfsr_q[0]);
	assign last_bit  = (bit_q == BW'(AMBE_BITS - 1));
	assign last_word = (word_q == WIDX'(WORDS - 1));

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ekvc_pkg::BK_IDLE: begin
				if (q_valid) begin
					state_nx = build_go ? ekvc_pkg::BK_BUILD : ekvc_pkg::BK_EMIT;
				end
			end
			ekvc_pkg::BK_BUILD: begin
				if (last_bit && last_word) begin
					state_nx = ekvc_pkg::BK_EMIT;
				end
			end
			ekvc_pkg::BK_EMIT: begin
				if (out_free) begin
					state_nx = ekvc_pkg::BK_IDLE;
				end
			end
			default: state_nx = ekvc_pkg::BK_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ekvc_pkg::BK_IDLE: begin
				q_pop  = q_valid;
				mem_re = q_valid && (q_item.kind == ekvc_pkg::KIND_CRYPT) && crypt_hit;
			end
			ekvc_pkg::BK_BUILD: begin
				mem_we = last_bit;
			end
			ekvc_pkg::BK_EMIT: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	// Keystream memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ks_mem[word_q] <= slice_nx;
		end
		if (mem_re) begin
			rd_q <= ks_mem[q_item.word_index[WIDX-1:0]];
		end
	end

	assign ks_ext = 64'(rd_q);

	// Pending result and walker data
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pend_bits_q   <= dec_bits;
			pend_status_q <= dec_status;
			pend_xor_q    <= mem_re;
			lfsr_q        <= cfg.scrambler_key[ekvc_pkg::LFSR_W-1:0];
			slice_q       <= '0;
		end else if (state_q == ekvc_pkg::BK_BUILD) begin
			lfsr_q  <= lfsr_nx;
			slice_q <= last_bit ? '0 : slice_nx;
		end
		if (load_out) begin
			res_q    <= pend_bits_q
				^ (pend_xor_q ? ks_ext[ekvc_pkg::VOICE_W-1:0] : '0);
			status_q <= pend_status_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ekvc_pkg::BK_IDLE;
			ks_valid_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			word_q     <= '0;
			bit_q      <= '0;
		end else begin
			state_q <= state_nx;
			if (q_pop && dec_drop) begin
				ks_valid_q <= 1'b0;
			end else if (mem_we && last_word) begin
				ks_valid_q <= 1'b1;
			end
			if (q_pop) begin
				word_q <= '0;
				bit_q  <= '0;
			end else if (state_q == ekvc_pkg::BK_BUILD) begin
				bit_q <= last_bit ? '0 : bit_q + BW'(1);
				if (last_bit) begin
					word_q <= word_q + WIDX'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = m_tvalid_q;
	assign result_bits = res_q;
	assign status      = status_q;

	// Sequencer checks
	a_we_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ekvc_pkg::BK_BUILD)
		else $error("keystream write outside build");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !load_out)
		else $error("waiting result overwritten");
	a_valid_after_build: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ks_valid_q) |-> $past(state_q == ekvc_pkg::BK_BUILD))
		else $error("keystream marked valid outside build");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ekvc_pkg::BK_IDLE)
		else $error("item taken while busy");

endmodule

[hdl/ehr_keystream_voice_crypt_unit.sv]
`timescale 1ns / 1ps
// Crypt, clear and pass items go through the input queue, the pending-result register
// and the output register. A build item first writes all WORDS words of keystream memory,
// one keystream bit per cycle from the LFSR walker in the back end, then gives its result.
// The back end works on one item at a time and pops the next only after the last result is
// loaded, which waits on m_tready; a build holds the back end. A 2-entry queue sits between.
// Reset (arst_n low, asynchronous): registers to 0, keystream dropped, queue and output empty.

module ehr_keystream_voice_crypt_unit #(
	parameter int WORDS     = 32,
	parameter int AMBE_BITS = 49
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input beats
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [1:0]                        s_tuser,   // op
	input  logic [63:0]                       s_tdata,   // word_index[7:0], voice_bits[56:8]
	// Result beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2:0]                        m_tuser,   // status
	output logic [55:0]                       m_tdata,   // result_bits[48:0], zero pad
	// Register writes
	input  logic                              cfg_we,
	input  logic [ekvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ekvc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	ekvc_pkg::cfg_t               cfg_q;
	ekvc_pkg::q_item_t            q_item;
	logic                         q_valid;
	logic                         q_pop;
	logic [ekvc_pkg::VOICE_W-1:0] result_bits;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ekvc_pkg::REG_CIPHER_TYPE:   cfg_q.cipher_type   <= cfg_wdata[1:0];
				ekvc_pkg::REG_KEY_ID:        cfg_q.key_id        <= cfg_wdata[7:0];
				ekvc_pkg::REG_SCRAMBLER_KEY: cfg_q.scrambler_key <= cfg_wdata;
				ekvc_pkg::REG_KEY_LENGTH:    cfg_q.key_length    <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	ekvc_front #(
		.WORDS (WORDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ekvc_back #(
		.WORDS     (WORDS),
		.AMBE_BITS (AMBE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.result_bits (result_bits),
		.status      (m_tuser)
	);

	assign m_tdata = {7'd0, result_bits};

endmodule

[tb/ehr_keystream_voice_crypt_unit_test.sv]
`timescale 1ns / 1ps

module ehr_keystream_voice_crypt_unit_test;

	localparam int KS_WORDS     = 32;
	localparam int KS_BITS      = 49;
	localparam int TOTAL_ITEMS  = 1850;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 1600;
	localparam int PRINT_CAP    = 40;

	// op code with no operation behind it; the block passes the word through
	localparam logic [ekvc_pkg::OP_W-1:0] OP_SPARE = 2'd3;
	localparam logic [ekvc_pkg::VOICE_W-1:0] VOICE_ONES = {ekvc_pkg::VOICE_W{1'b1}};

	// cipher types that never build
	localparam logic [1:0] CIPHER_NONE = 2'd0;
	localparam logic [1:0] CIPHER_DES  = 2'd2;
	localparam logic [1:0] CIPHER_AES  = 2'd3;

	typedef struct {
		logic [ekvc_pkg::VOICE_W-1:0]  bits;
		logic [ekvc_pkg::STATUS_W-1:0] status;
	} voice_result_t;

	typedef struct {
		bit                              is_write;
		logic [ekvc_pkg::CFG_IDX_W-1:0]  reg_index;
		logic [ekvc_pkg::CFG_DATA_W-1:0] reg_value;
		logic [ekvc_pkg::OP_W-1:0]       op;
		logic [ekvc_pkg::IDX_W-1:0]      word_index;
		logic [ekvc_pkg::VOICE_W-1:0]    voice;
		bit                              typed;
		logic [ekvc_pkg::VOICE_W-1:0]    want_bits;
		logic [ekvc_pkg::STATUS_W-1:0]   want_status;
	} stim_row_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [1:0]                      s_tuser   = '0;	// op
	logic [63:0]                     s_tdata   = '0;	// word_index[7:0], voice_bits[56:8], zero pad
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [2:0]                      m_tuser;		// status
	logic [55:0]                     m_tdata;		// result_bits[48:0], zero pad
	logic                            cfg_we    = 1'b0;
	logic [ekvc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ekvc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// predictor state: register copy and keystream copy
	ekvc_pkg::cfg_t               cfg_copy = '0;
	logic [ekvc_pkg::VOICE_W-1:0] ks_copy [KS_WORDS];
	logic                         ks_live = 1'b0;

	voice_result_t awaited_results [$];
	stim_row_t     directed_rows [$];

	int unsigned cycle_count     = 0;
	int          mismatches      = 0;
	int          items_sent      = 0;
	int          results_checked = 0;
	int          words_crypted   = 0;
	int          builds_done     = 0;
	int          builds_refused  = 0;
	int          key_settings    = 0;
	int          burst_left      = 0;

	ehr_keystream_voice_crypt_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("ehr_keystream_voice_crypt_unit test failed");
			$finish;
		end
	end

	// receiver back-pressure: rotating stall pattern, swapped at random intervals
	logic [15:0] stall_pattern = '0;
	int unsigned pattern_left  = 0;
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			pattern_left <= $urandom_range(16, 300);
			case ($urandom_range(0, 3))
				0: stall_pattern <= '0;
				1: stall_pattern <= 16'($urandom);
				2: stall_pattern <= 16'($urandom) & 16'($urandom);
				default: stall_pattern <= 16'($urandom) | 16'($urandom);
			endcase
		end else begin
			pattern_left  <= pattern_left - 1;
			stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
		end
		m_tready <= ~stall_pattern[0];
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result beats against the oldest awaited result
	always @(posedge clk) begin : check_results
		voice_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with nothing awaited", 64'(m_tdata), 64'd0);
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata[ekvc_pkg::VOICE_W-1:0] !== want.bits)
					report_mismatch("result_bits", 64'(m_tdata[ekvc_pkg::VOICE_W-1:0]),
						64'(want.bits));
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				results_checked++;
			end
		end
	end

	// predictor: one input beat in, the expected result out, state updated
	function automatic voice_result_t predict_voice_result(
			input logic [ekvc_pkg::OP_W-1:0] op,
			input logic [ekvc_pkg::IDX_W-1:0] word_index,
			input logic [ekvc_pkg::VOICE_W-1:0] voice);
		voice_result_t                r;
		logic [ekvc_pkg::LFSR_W-1:0]  lfsr;
		logic [ekvc_pkg::VOICE_W-1:0] slice;
		r.bits   = '0;
		r.status = ekvc_pkg::STS_NO_KS;
		case (op)
			ekvc_pkg::OP_CRYPT: begin
				r.bits = voice;
				if (!ks_live || cfg_copy.cipher_type != ekvc_pkg::CIPHER_SCRAMBLER) begin
					r.status = ekvc_pkg::STS_NO_KS;
				end else if (word_index >= KS_WORDS) begin
					r.status = ekvc_pkg::STS_RANGE;
				end else begin
					r.bits   = voice ^ ks_copy[word_index[4:0]];
					r.status = ekvc_pkg::STS_CRYPTED;
				end
			end
			ekvc_pkg::OP_BUILD: begin
				if (cfg_copy.cipher_type == ekvc_pkg::CIPHER_SCRAMBLER &&
						cfg_copy.key_length == ekvc_pkg::KEY_LEN_SCRAMBLER &&
						cfg_copy.key_id != 0 && cfg_copy.key_id <= ekvc_pkg::KEY_ID_MAX &&
						cfg_copy.scrambler_key != 0 &&
						cfg_copy.scrambler_key <= ekvc_pkg::KEY_MAX) begin
					// LSB before each step, first bit of a word at the top
					lfsr = cfg_copy.scrambler_key[ekvc_pkg::LFSR_W-1:0];
					for (int w = 0; w < KS_WORDS; w++) begin
						slice = '0;
						for (int b = 0; b < KS_BITS; b++) begin
							slice = {slice[ekvc_pkg::VOICE_W-2:0], lfsr[0]};
							lfsr  = {lfsr[0] ^ lfsr[1], lfsr[ekvc_pkg::LFSR_W-1:1]};
						end
						ks_copy[w] = slice;
					end
					ks_live  = 1'b1;
					r.status = ekvc_pkg::STS_BUILT;
				end else begin
					ks_live  = 1'b0;
					r.status = ekvc_pkg::STS_REFUSED;
				end
			end
			ekvc_pkg::OP_CLEAR: ks_live = 1'b0;
			default: r.bits = voice;
		endcase
		return r;
	endfunction

	// drop valid and let every awaited result arrive
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// register write; cfg_we stays high across back-to-back writes
	task automatic write_register(input logic [ekvc_pkg::CFG_IDX_W-1:0] index,
			input logic [ekvc_pkg::CFG_DATA_W-1:0] value, input bit last);
		if (!cfg_we)
			wait_for_results();
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		case (index)
			ekvc_pkg::REG_CIPHER_TYPE:   cfg_copy.cipher_type   = value[1:0];
			ekvc_pkg::REG_KEY_ID:        cfg_copy.key_id        = value[7:0];
			ekvc_pkg::REG_SCRAMBLER_KEY: cfg_copy.scrambler_key = value;
			default:                     cfg_copy.key_length    = value[5:0];
		endcase
		@(posedge clk);
		if (last) begin
			cfg_we <= 1'b0;
			key_settings++;
		end
	endtask

	// one input beat; returns at the accepting edge with tvalid still high
	task automatic send_word(input logic [ekvc_pkg::OP_W-1:0] op,
			input logic [ekvc_pkg::IDX_W-1:0] word_index,
			input logic [ekvc_pkg::VOICE_W-1:0] voice, input bit typed,
			input logic [ekvc_pkg::VOICE_W-1:0] want_bits,
			input logic [ekvc_pkg::STATUS_W-1:0] want_status);
		voice_result_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, voice, word_index};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = predict_voice_result(op, word_index, voice);
		if (typed) begin
			r.bits   = want_bits;
			r.status = want_status;
		end
		awaited_results.push_back(r);
		items_sent++;
		case (r.status)
			ekvc_pkg::STS_CRYPTED: words_crypted++;
			ekvc_pkg::STS_BUILT:   builds_done++;
			ekvc_pkg::STS_REFUSED: builds_refused++;
			default: ;
		endcase
	endtask

	// sender bursts and gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic void add_word(input logic [ekvc_pkg::OP_W-1:0] op,
			input logic [ekvc_pkg::IDX_W-1:0] idx,
			input logic [ekvc_pkg::VOICE_W-1:0] voice, input bit typed,
			input logic [ekvc_pkg::VOICE_W-1:0] want_bits,
			input logic [ekvc_pkg::STATUS_W-1:0] want_status);
		stim_row_t row;
		row = '{default: '0};
		row.op          = op;
		row.word_index  = idx;
		row.voice       = voice;
		row.typed       = typed;
		row.want_bits   = want_bits;
		row.want_status = want_status;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_write(input logic [ekvc_pkg::CFG_IDX_W-1:0] index,
			input logic [ekvc_pkg::CFG_DATA_W-1:0] value);
		stim_row_t row;
		row = '{default: '0};
		row.is_write  = 1'b1;
		row.reg_index = index;
		row.reg_value = value;
		directed_rows.push_back(row);
	endfunction

	// one key setting followed by a stretch of mostly crypt beats
	task automatic run_random_phase(input int n_items);
		logic [ekvc_pkg::CFG_DATA_W-1:0] cipher, id, key, len;
		logic [ekvc_pkg::OP_W-1:0]       op;
		logic [ekvc_pkg::IDX_W-1:0]      idx;
		logic [ekvc_pkg::VOICE_W-1:0]    voice;
		int                              mode;
		int                              pick;
		mode   = $urandom_range(0, 9);
		cipher = 16'(ekvc_pkg::CIPHER_SCRAMBLER);
		id     = 16'($urandom_range(1, 63));
		key    = 16'($urandom_range(1, 16'h7FFF));
		len    = 16'(ekvc_pkg::KEY_LEN_SCRAMBLER);
		if ($urandom_range(0, 3) == 0)
			id = $urandom_range(0, 1) ? 16'd63 : 16'd1;
		if ($urandom_range(0, 3) == 0)
			key = $urandom_range(0, 1) ? 16'h7FFF : 16'd1;
		if (mode >= 6 && mode <= 7) begin
			// a valid key with one field broken
			case ($urandom_range(0, 3))
				0: begin
					pick = $urandom_range(0, 2);
					case (pick)
						0: cipher = 16'(CIPHER_NONE);
						1: cipher = 16'(CIPHER_DES);
						default: cipher = 16'(CIPHER_AES);
					endcase
				end
				1: id  = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(64, 255));
				2: key = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(16'h8000, 16'hFFFF));
				default: len = $urandom_range(0, 1) ? 16'($urandom_range(0, 1))
					: 16'($urandom_range(3, 63));
			endcase
		end else if (mode >= 8) begin
			// anything at all, upper bits included
			cipher = 16'($urandom);
			id     = 16'($urandom);
			key    = 16'($urandom);
			len    = 16'($urandom);
		end
		write_register(ekvc_pkg::REG_CIPHER_TYPE, cipher, 1'b0);
		write_register(ekvc_pkg::REG_KEY_ID, id, 1'b0);
		write_register(ekvc_pkg::REG_SCRAMBLER_KEY, key, 1'b0);
		write_register(ekvc_pkg::REG_KEY_LENGTH, len, 1'b1);

		// most phases rebuild; the rest keep the old keystream under new registers
		if ($urandom_range(0, 4) != 0) begin
			send_word(ekvc_pkg::OP_BUILD, 8'($urandom), 49'({$urandom, $urandom}), 1'b0,
				'0, '0);
			pace_sender();
		end
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				op = ekvc_pkg::OP_BUILD;
			else if (pick < 5)
				op = ekvc_pkg::OP_CLEAR;
			else if (pick < 9)
				op = OP_SPARE;
			else
				op = ekvc_pkg::OP_CRYPT;
			idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(32, 255))
				: 8'($urandom_range(0, KS_WORDS - 1));
			case ($urandom_range(0, 15))
				0:       voice = '0;
				1:       voice = VOICE_ONES;
				default: voice = 49'({$urandom, $urandom});
			endcase
			send_word(op, idx, voice, 1'b0, '0, '0);
			pace_sender();
		end
	endtask

	initial begin
		// directed table: typed rows carry their result, the rest go to the predictor
		add_word(ekvc_pkg::OP_CRYPT, 8'd0, VOICE_ONES, 1'b1, VOICE_ONES, ekvc_pkg::STS_NO_KS);
		add_word(OP_SPARE, 8'd255, 49'h1_5555_5555_5555, 1'b1, 49'h1_5555_5555_5555,
			ekvc_pkg::STS_NO_KS);
		add_word(ekvc_pkg::OP_CLEAR, 8'd17, VOICE_ONES, 1'b1, '0, ekvc_pkg::STS_NO_KS);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_write(ekvc_pkg::REG_CIPHER_TYPE, 16'(ekvc_pkg::CIPHER_SCRAMBLER));
		add_write(ekvc_pkg::REG_KEY_ID, 16'd1);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'd1);
		add_write(ekvc_pkg::REG_KEY_LENGTH, 16'd2);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, VOICE_ONES, 1'b1, '0, ekvc_pkg::STS_BUILT);
		add_word(ekvc_pkg::OP_CRYPT, 8'd0, '0, 1'b0, '0, '0);
		add_word(ekvc_pkg::OP_CRYPT, 8'd31, VOICE_ONES, 1'b0, '0, '0);
		add_word(ekvc_pkg::OP_CRYPT, 8'd32, 49'h0_AAAA_AAAA_AAAA, 1'b1, 49'h0_AAAA_AAAA_AAAA,
			ekvc_pkg::STS_RANGE);
		add_word(ekvc_pkg::OP_CRYPT, 8'd255, VOICE_ONES, 1'b1, VOICE_ONES, ekvc_pkg::STS_RANGE);
		// cipher type is checked again at crypt time
		add_write(ekvc_pkg::REG_CIPHER_TYPE, 16'(CIPHER_DES));
		add_word(ekvc_pkg::OP_CRYPT, 8'd5, 49'h1_2345_6789_ABCD, 1'b1, 49'h1_2345_6789_ABCD,
			ekvc_pkg::STS_NO_KS);
		add_write(ekvc_pkg::REG_CIPHER_TYPE, 16'(ekvc_pkg::CIPHER_SCRAMBLER));
		add_word(ekvc_pkg::OP_CRYPT, 8'd5, 49'h1_2345_6789_ABCD, 1'b0, '0, '0);
		// new key registers leave the stored keystream alone until a build
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'h7FFF);
		add_write(ekvc_pkg::REG_KEY_ID, 16'd63);
		add_word(ekvc_pkg::OP_CRYPT, 8'd1, VOICE_ONES, 1'b0, '0, '0);
		add_word(ekvc_pkg::OP_BUILD, 8'd200, '0, 1'b1, '0, ekvc_pkg::STS_BUILT);
		add_word(ekvc_pkg::OP_CRYPT, 8'd31, '0, 1'b0, '0, '0);
		// key id, scrambler key and key length rules each broken on its own
		add_write(ekvc_pkg::REG_KEY_ID, 16'd64);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_word(ekvc_pkg::OP_CRYPT, 8'd0, VOICE_ONES, 1'b1, VOICE_ONES, ekvc_pkg::STS_NO_KS);
		add_write(ekvc_pkg::REG_KEY_ID, 16'd63);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'h8000);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'h7FFF);
		add_write(ekvc_pkg::REG_KEY_LENGTH, 16'd3);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_write(ekvc_pkg::REG_KEY_LENGTH, 16'd2);
		add_write(ekvc_pkg::REG_KEY_ID, 16'd0);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_write(ekvc_pkg::REG_KEY_ID, 16'd63);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'd0);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		// every register at its top value
		add_write(ekvc_pkg::REG_CIPHER_TYPE, 16'hFFFF);
		add_write(ekvc_pkg::REG_KEY_ID, 16'hFFFF);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'hFFFF);
		add_write(ekvc_pkg::REG_KEY_LENGTH, 16'hFFFF);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_REFUSED);
		add_write(ekvc_pkg::REG_CIPHER_TYPE, 16'(ekvc_pkg::CIPHER_SCRAMBLER));
		add_write(ekvc_pkg::REG_KEY_ID, 16'd1);
		add_write(ekvc_pkg::REG_SCRAMBLER_KEY, 16'h7FFF);
		add_write(ekvc_pkg::REG_KEY_LENGTH, 16'd2);
		add_word(ekvc_pkg::OP_BUILD, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_BUILT);
		add_word(OP_SPARE, 8'd7, 49'h0_F0F0_F0F0_F0F0, 1'b1, 49'h0_F0F0_F0F0_F0F0,
			ekvc_pkg::STS_NO_KS);
		add_word(ekvc_pkg::OP_CLEAR, 8'd0, '0, 1'b1, '0, ekvc_pkg::STS_NO_KS);
		add_word(ekvc_pkg::OP_CRYPT, 8'd3, 49'h1_0000_0000_0001, 1'b1, 49'h1_0000_0000_0001,
			ekvc_pkg::STS_NO_KS);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_value,
					i + 1 >= directed_rows.size() || !directed_rows[i + 1].is_write);
			end else begin
				send_word(directed_rows[i].op, directed_rows[i].word_index,
					directed_rows[i].voice, directed_rows[i].typed,
					directed_rows[i].want_bits, directed_rows[i].want_status);
				pace_sender();
			end
		end

		while (items_sent < TOTAL_ITEMS)
			run_random_phase($urandom_range(60, 220));

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d input beats and %0d results under %0d key settings:",
			items_sent, results_checked, key_settings);
		$display("  %0d words crypted, %0d keystreams built, %0d builds refused",
			words_crypted, builds_done, builds_refused);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("ehr_keystream_voice_crypt_unit test passed");
		end else begin
			$display("ehr_keystream_voice_crypt_unit test failed");
		end
		$finish;
	end

endmodule
